### sv/sha_pkg.sv
`default_nettype none
package sha_pkg;

   localparam int unsigned RoundCount = 64;

   typedef logic [31:0] word_type;

   function automatic word_type round_constant(input logic [5:0] idx);
      word_type k;
      begin
         case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = '0;
         endcase
         return k;
      end
   endfunction

   function automatic word_type initial_hash(input logic [2:0] idx);
      word_type h;
      begin
         case (idx)
            3'd0: h = 32'h6a09e667;  3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;  3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;  3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;  3'd7: h = 32'h5be0cd19;
            default: h = '0;
         endcase
         return h;
      end
   endfunction

   // Control from the sequencer to the compression core.
   typedef struct packed {
      logic       start;
      logic [5:0] round;
      logic       round_en;
   } core_ctrl_type;

endpackage
`default_nettype wire

### sv/sha_if.sv
`default_nettype none
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;
   modport source (output valid, data_byte, has_byte, end_of_message, input ready);
   modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        last_word;
   modport source (output valid, digest_word, last_word, input ready);
   modport sink   (input valid, digest_word, last_word, output ready);
endinterface
`default_nettype wire

### sv/sha_core.sv
`default_nettype none
module sha_core
   import sha_pkg::*;
(
   input  wire logic          clock,
   input  wire core_ctrl_type ctrl,
   input  wire word_type      w_word,
   input  wire word_type      h_in [8],
   output word_type           h_out [8]
);

   word_type v_ff [8];
   word_type v_in [8];

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   word_type s1, ch, s0, maj, t1, t2;

   always_comb begin
      s1  = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      s0  = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1  = v_ff[7] + s1 + ch + round_constant(ctrl.round) + w_word;
      t2  = s0 + maj;
      v_in = v_ff;
      if (ctrl.start) begin
         v_in = h_in;
      end else if (ctrl.round_en) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) begin
         h_out[i] = h_in[i] + v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end

endmodule
`default_nettype wire

### sv/sha256_message_digest.sv
`default_nettype none
// SHA-256 digest engine that takes one message byte per beat. Bytes are packed
// big-endian into a 64-byte block memory. A beat that neither completes a
// block nor ends the message leaves the engine idle, so such beats can follow
// back to back. When a block fills, the engine reads it back one byte per
// cycle and packs it into a 16-word schedule memory, loads the working
// variables and runs the 64 rounds. The schedule memory read taps are
// registered, so each round has a read state, ST_RD, that reads the taps,
// and a compute state, ST_RND, that computes and writes back. The result is
// then folded into the chaining value; input is not accepted until the block
// is done. The beat that ends the message, with or without a byte, starts a
// padding sweep that writes 0x80, zeros and, where it fits, the 64-bit bit
// length over the rest of the block, one byte per cycle; when that beat fills
// the block, the sweep starts from address zero after the compression. With
// 56 or more bytes pending, the length goes into a second block, which adds a
// full sweep from address zero and a second compression. The eight digest
// words then leave as eight result beats, word H0 first, one per cycle while
// the receiver is ready, and the engine returns to the standard initial hash
// value. Input is held off from the end beat until the last digest beat is
// taken.
module sha256_message_digest
   import sha_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   sha_req_if.sink   req,
   sha_rsp_if.source rsp
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_PACK, ST_LOAD, ST_RD, ST_RND, ST_FOLD, ST_PAD, ST_OUT
   } state_type;

   state_type  state_ff;
   logic [5:0] fill_ff;       // pending bytes in the block buffer
   logic [63:0] bitlen_ff;
   logic       final_ff;      // current compression is the closing block
   logic       extra_ff;      // the message has ended; padding is still due
   logic       mark_ff;       // the 0x80 marker byte has been written
   logic [6:0] rnd_ff;        // round counter, also byte counter in the pack
   logic [2:0] out_idx_ff;
   word_type   hash_ff [8];

   // Block buffer, 64 bytes, one write port and one read port.
   logic [7:0] buf_mem [64];
   // Schedule window, 16 words.
   word_type   win_mem [16];

   word_type   h_out [8];
   core_ctrl_type ctrl;

   // Byte accept
   logic       acc;
   logic [6:0] fill_sum;
   assign req.ready = (state_ff == ST_IDLE);
   assign acc = req.valid && req.ready;
   assign fill_sum = {1'b0, fill_ff} + {6'd0, req.has_byte};

   // Buffer write mux: accepted bytes, or padding bytes during ST_PAD.
   logic       bw_en;
   logic [5:0] bw_addr;
   logic [7:0] bw_data;

   // Pack reads: one byte per cycle, shifted into a word.
   logic [5:0] br_addr;
   logic [7:0] br_ff;
   word_type   pack_ff;
   word_type   pack_word;

   // Window read taps, registered.
   logic [3:0] t_idx;
   word_type   x2_ff, x7_ff, x15_ff, x16_ff;
   word_type   w_word;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   assign t_idx = rnd_ff[3:0];
   assign pack_word = {pack_ff[23:0], br_ff};

   always_ff @(posedge clock) begin
      if (bw_en) buf_mem[bw_addr] <= bw_data;
      br_ff <= buf_mem[br_addr];
   end

   // During the pack, byte k arrives from the memory at count k + 1, so a word
   // is complete at every count that is a nonzero multiple of four.
   always_ff @(posedge clock) begin
      if (state_ff == ST_PACK && rnd_ff != 7'd0) pack_ff <= pack_word;
   end

   always_ff @(posedge clock) begin
      x2_ff  <= win_mem[t_idx - 4'd2];
      x7_ff  <= win_mem[t_idx - 4'd7];
      x15_ff <= win_mem[t_idx - 4'd15];
      x16_ff <= win_mem[t_idx];
      if (state_ff == ST_PACK && rnd_ff[1:0] == 2'd0 && rnd_ff != 7'd0) begin
         win_mem[rnd_ff[5:2] - 4'd1] <= pack_word;
      end else if (state_ff == ST_RND && rnd_ff >= 7'd16) begin
         win_mem[t_idx] <= w_word;
      end
   end

   always_comb begin
      if (rnd_ff < 7'd16) begin
         w_word = x16_ff;
      end else begin
         w_word = (rotr(x2_ff, 17) ^ rotr(x2_ff, 19) ^ (x2_ff >> 10)) + x7_ff
                + (rotr(x15_ff, 7) ^ rotr(x15_ff, 18) ^ (x15_ff >> 3)) + x16_ff;
      end
   end

   // Padding byte at sweep position rnd_ff. The length goes into this block
   // when the marker has already gone out or when it leaves room for it.
   logic       len_blk;
   logic [7:0] pad_byte;
   assign len_blk = mark_ff || (fill_ff < 6'd56);
   always_comb begin
      pad_byte = 8'h00;
      if (!mark_ff && rnd_ff[5:0] == fill_ff) begin
         pad_byte = 8'h80;
      end else if (len_blk && rnd_ff[5:0] >= 6'd56) begin
         pad_byte = bitlen_ff[{~rnd_ff[2:0], 3'b000} +: 8];
      end
   end

   always_comb begin
      bw_en = 1'b0;
      bw_addr = fill_ff;
      bw_data = req.data_byte;
      if (acc && req.has_byte) bw_en = 1'b1;
      if (state_ff == ST_PAD) begin
         bw_en   = 1'b1;
         bw_addr = rnd_ff[5:0];
         bw_data = pad_byte;
      end
      br_addr = rnd_ff[5:0];
   end

   always_comb begin
      ctrl.start    = (state_ff == ST_LOAD);
      ctrl.round    = rnd_ff[5:0];
      ctrl.round_en = (state_ff == ST_RND);
   end

   sha_core u_core (
      .clock(clock), .ctrl(ctrl), .w_word(w_word),
      .h_in(hash_ff), .h_out(h_out)
   );

   assign rsp.valid       = (state_ff == ST_OUT);
   assign rsp.digest_word = hash_ff[out_idx_ff];
   assign rsp.last_word   = (out_idx_ff == 3'd7);

   // Sequencer. A closing sweep starts at the pending byte count: the marker,
   // then zeros, then the length if it fits. When it does not fit, or when the
   // closing byte itself filled the block, a sweep from address zero
   // follows the compression, and that one carries the length.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= '0;
         bitlen_ff  <= '0;
         final_ff   <= 1'b0;
         extra_ff   <= 1'b0;
         mark_ff    <= 1'b0;
         rnd_ff     <= '0;
         out_idx_ff <= '0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= initial_hash(3'(i));
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (acc) begin
                  if (req.has_byte) bitlen_ff <= bitlen_ff + 64'd8;
                  fill_ff  <= fill_sum[5:0];
                  final_ff <= 1'b0;
                  extra_ff <= req.end_of_message;
                  mark_ff  <= 1'b0;
                  rnd_ff   <= '0;
                  if (fill_sum[6]) begin
                     state_ff <= ST_PACK;
                  end else if (req.end_of_message) begin
                     state_ff <= ST_PAD;
                     rnd_ff   <= {1'b0, fill_sum[5:0]};
                  end
               end
            end
            ST_PAD: begin
               if (rnd_ff[5:0] == 6'd63) begin
                  final_ff <= len_blk;
                  mark_ff  <= 1'b1;
                  state_ff <= ST_PACK;
                  rnd_ff   <= '0;
               end else begin
                  rnd_ff <= rnd_ff + 7'd1;
               end
            end
            ST_PACK: begin
               if (rnd_ff == 7'd64) begin
                  state_ff <= ST_LOAD;
                  rnd_ff   <= '0;
               end else begin
                  rnd_ff <= rnd_ff + 7'd1;
               end
            end
            ST_LOAD: state_ff <= ST_RD;
            ST_RD:   state_ff <= ST_RND;
            ST_RND: begin
               if (rnd_ff == 7'd63) begin
                  state_ff <= ST_FOLD;
               end else begin
                  rnd_ff   <= rnd_ff + 7'd1;
                  state_ff <= ST_RD;
               end
            end
            ST_FOLD: begin
               for (int i = 0; i < 8; i++) hash_ff[i] <= h_out[i];
               rnd_ff  <= '0;
               fill_ff <= '0;
               if (final_ff) begin
                  state_ff   <= ST_OUT;
                  out_idx_ff <= '0;
               end else if (extra_ff) begin
                  state_ff <= ST_PAD;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_OUT: begin
               if (rsp.ready) begin
                  out_idx_ff <= out_idx_ff + 3'd1;
                  if (out_idx_ff == 3'd7) begin
                     state_ff  <= ST_IDLE;
                     fill_ff   <= '0;
                     bitlen_ff <= '0;
                     final_ff  <= 1'b0;
                     extra_ff  <= 1'b0;
                     mark_ff   <= 1'b0;
                     for (int i = 0; i < 8; i++) hash_ff[i] <= initial_hash(3'(i));
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("accept while busy");
   a_out_only: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (state_ff == ST_OUT)) else $error("stray digest beat");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.last_word) |=> (state_ff == ST_IDLE))
      else $error("no return to idle");
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RND) |-> (rnd_ff < 7'd64)) else $error("round overrun");
`endif

endmodule
`default_nettype wire
